/* rtl/core/clsr_pkg.sv */
// ----------------------------------------------------------------------------
// clsr_pkg: shared types and constants of the combined LCG shuffle generator
// Moduli, multipliers, fold factors and the request word of the mod-mult unit.
// ----------------------------------------------------------------------------
package clsr_pkg;

  typedef logic [30:0]        word_t;
  typedef logic signed [31:0] seed_t;

  // first generator
  localparam logic [31:0] MOD1       = 32'd2147483563;
  localparam logic [15:0] MUL1       = 16'd40014;
  // 2^31 mod MOD1
  localparam logic [7:0]  FOLD1      = 8'd85;
  localparam logic [31:0] MOD1_LESS1 = 32'd2147483562;

  // second generator
  localparam logic [31:0] MOD2       = 32'd2147483399;
  localparam logic [15:0] MUL2       = 16'd40692;
  // 2^31 mod MOD2
  localparam logic [7:0]  FOLD2      = 8'd249;

  localparam word_t       SECOND_RESET = 31'd123456789;

  // generator select for the shared unit
  localparam logic GEN_FIRST  = 1'b0;
  localparam logic GEN_SECOND = 1'b1;

  typedef struct packed {
    logic vld;
    logic sel;
  } mm_req_t;

endpackage

/* rtl/core/clsr_in_if.sv */
// ----------------------------------------------------------------------------
// clsr_in_if: input word channel
// Carries the mode bit and the signed seed under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface clsr_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  clsr_pkg::seed_t seed;

  modport source (output valid, mode, seed, input ready);
  modport sink   (input valid, mode, seed, output ready);
endinterface

/* rtl/core/clsr_out_if.sv */
// ----------------------------------------------------------------------------
// clsr_out_if: result word channel
// Carries the combined random word and the updated first state.
// ----------------------------------------------------------------------------
interface clsr_out_if;
  logic            valid;
  logic            ready;
  clsr_pkg::word_t random_word;
  clsr_pkg::word_t next_seed;

  modport source (output valid, random_word, next_seed, input ready);
  modport sink   (input valid, random_word, next_seed, output ready);
endinterface

/* rtl/core/clsr_ram.sv */
// ----------------------------------------------------------------------------
// clsr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* rtl/core/clsr_mmul.sv */
// ----------------------------------------------------------------------------
// clsr_mmul: shared modular multiply unit
// Two-stage pipeline: v * mul, then fold of the bits above 2^31 and one
// conditional subtract of the modulus.
// ----------------------------------------------------------------------------
module clsr_mmul (
  input  logic              clk,
  input  logic              rst_n,
  input  clsr_pkg::mm_req_t req,
  input  logic [31:0]       opnd,
  output logic              res_vld,
  output clsr_pkg::word_t   res
);

  logic        vld1_r;
  logic        sel1_r;
  logic [47:0] prod_r;
  logic        vld2_r;
  logic [15:0] mul;
  logic [16:0] hi;
  logic [7:0]  fold_c;
  logic [31:0] fold_mod;
  logic [31:0] fold_sum;
  logic [31:0] reduced;

  assign mul = (req.sel == clsr_pkg::GEN_SECOND) ? clsr_pkg::MUL2 : clsr_pkg::MUL1;

  // fold: hi * 2^31 + lo == hi * (2^31 mod m) + lo, below twice the modulus
  assign hi       = prod_r[47:31];
  assign fold_c   = (sel1_r == clsr_pkg::GEN_SECOND) ? clsr_pkg::FOLD2 : clsr_pkg::FOLD1;
  assign fold_mod = (sel1_r == clsr_pkg::GEN_SECOND) ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
  assign fold_sum = 32'(25'(hi) * 25'(fold_c)) + {1'b0, prod_r[30:0]};
  assign reduced  = (fold_sum >= fold_mod) ? (fold_sum - fold_mod) : fold_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= req.vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    sel1_r <= req.sel;
    prod_r <= 48'(opnd) * 48'(mul);
    res    <= reduced[30:0];
  end

  assign res_vld = vld2_r;

endmodule

/* rtl/core/combined_lcg_shuffle_rng_top.sv */
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top: combined LCG generator with shuffle table
// Two multiplicative congruential generators share one modular multiply
// unit; their outputs meet in a table of past first-generator values.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------
//  in_ch    | in  | valid / ready  | mode (1), seed (32, signed)
//  out_ch   | out | valid / ready  | random_word (31), next_seed (31)
//
//  A draw from the held state passes through the accept, a check of the
//  state, then five sequencer steps around the shared two-stage mod-mult
//  unit and the table RAM's registered read.
//  A reinitializing seed adds the INIT0 state, then TABLE_SIZE + 8 steps
//  that each issue to the unit, wait out its pipeline and take the result.
//  Reset is synchronous, active low; the table needs no clearing pass, a
//  per-entry valid bit makes unwritten entries read as zero.
//  A stalled result holds in the output register; the block takes a new
//  word once the sequencer is idle, even while that result waits.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  clsr_in_if.sink     in_ch,
  clsr_out_if.source  out_ch
);

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int QW    = IDX_W + 1;
  localparam int MW    = IDX_W + 2;
  localparam int CNT_W = $clog2(TABLE_SIZE + 8);

  // index = last_output / DIVISOR, via a reciprocal and one correction
  localparam logic [31:0] DIVISOR    = 32'd1 + (clsr_pkg::MOD1_LESS1 / 32'(TABLE_SIZE));
  localparam logic [32:0] RECIP_FULL = 33'h1_0000_0000 / {1'b0, DIVISOR};
  localparam logic [MW-1:0] RECIP    = RECIP_FULL[MW-1:0];
  localparam logic [CNT_W-1:0] INIT_LAST = CNT_W'(TABLE_SIZE + 7);
  localparam logic [QW-1:0]    IDX_MAX_Q = QW'(TABLE_SIZE - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_INIT0     = 4'd2;
  localparam logic [3:0] S_INIT_ISS  = 4'd3;
  localparam logic [3:0] S_INIT_WAIT = 4'd4;
  localparam logic [3:0] S_INIT_TAKE = 4'd5;
  localparam logic [3:0] S_D0        = 4'd6;
  localparam logic [3:0] S_D1        = 4'd7;
  localparam logic [3:0] S_D2        = 4'd8;
  localparam logic [3:0] S_D3        = 4'd9;
  localparam logic [3:0] S_D4        = 4'd10;

  // control and architectural state (reset)
  logic [3:0]            state_r,        state_nxt;
  logic [31:0]           first_state_r,  first_state_nxt;
  clsr_pkg::word_t       second_state_r, second_state_nxt;
  clsr_pkg::word_t       last_output_r,  last_output_nxt;
  logic [TABLE_SIZE-1:0] tbl_vld_r,      tbl_vld_nxt;
  logic                  out_valid_r,    out_valid_nxt;

  // datapath registers (no reset)
  logic [31:0]           v_r,        v_nxt;
  logic [CNT_W-1:0]      cnt_r,      cnt_nxt;
  logic [QW-1:0]         q_r,        q_nxt;
  logic [QW+30:0]        qd_r,       qd_nxt;
  logic [IDX_W-1:0]      idx_r,      idx_nxt;
  clsr_pkg::word_t       out_word_r, out_word_nxt;
  clsr_pkg::word_t       out_seed_r, out_seed_nxt;

  // shared unit and table
  clsr_pkg::mm_req_t mm_req;
  logic [31:0]       mm_opnd;
  logic              mm_res_vld;
  clsr_pkg::word_t   mm_res;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  clsr_pkg::word_t   ram_wr_data;
  logic              ram_rd_en;
  clsr_pkg::word_t   ram_rd_data;

  // combinational helpers
  logic [31+MW-1:0]  q_prod;
  logic [QW-1:0]     q_inc;
  logic [QW-1:0]     q_sel;
  clsr_pkg::word_t   tbl_val;
  logic signed [32:0] diff;
  logic signed [32:0] diff_adj;
  logic              in_acc;
  logic              out_free;

  clsr_mmul u_mmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .opnd    (mm_opnd),
    .res_vld (mm_res_vld),
    .res     (mm_res)
  );

  clsr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_SIZE)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_acc             = in_ch.valid && (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;
  assign out_ch.next_seed   = out_seed_r;
  assign out_free           = !out_valid_r || out_ch.ready;

  // index path: estimate, then bump by one if the next multiple still fits
  assign q_prod  = (31+MW)'(last_output_r) * (31+MW)'(RECIP);
  assign q_inc   = q_r + QW'(1);
  assign q_sel   = ({{QW{1'b0}}, last_output_r} >= qd_r) ? q_inc : q_r;

  // combine: table entry minus second generator, wrapped into 1..MOD1-1
  assign tbl_val  = tbl_vld_r[idx_r] ? ram_rd_data : '0;
  assign diff     = $signed({2'b00, tbl_val}) - $signed({2'b00, second_state_r});
  assign diff_adj = (diff < 33'sd1) ? (diff + $signed({1'b0, clsr_pkg::MOD1_LESS1}))
                                    : diff;

  always_comb begin
    state_nxt        = state_r;
    first_state_nxt  = first_state_r;
    second_state_nxt = second_state_r;
    last_output_nxt  = last_output_r;
    tbl_vld_nxt      = tbl_vld_r;
    out_valid_nxt    = out_valid_r;
    v_nxt            = v_r;
    cnt_nxt          = cnt_r;
    q_nxt            = q_r;
    qd_nxt           = qd_r;
    idx_nxt          = idx_r;
    out_word_nxt     = out_word_r;
    out_seed_nxt     = out_seed_r;
    mm_req.vld       = 1'b0;
    mm_req.sel       = clsr_pkg::GEN_FIRST;
    mm_opnd          = first_state_r;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = idx_r;
    ram_wr_data      = first_state_r[30:0];
    ram_rd_en        = 1'b0;

    // drop the held result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode) begin
            first_state_nxt = in_ch.seed;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // zero or negative state forces a full reinit
        if ((first_state_r == 32'd0) || first_state_r[31]) begin
          v_nxt     = (first_state_r == 32'd0) ? 32'd1 : (32'd0 - first_state_r);
          state_nxt = S_INIT0;
        end else begin
          state_nxt = S_D0;
        end
      end
      S_INIT0: begin
        second_state_nxt = (v_r >= clsr_pkg::MOD2) ? 31'(v_r - clsr_pkg::MOD2) : v_r[30:0];
        cnt_nxt          = INIT_LAST;
        state_nxt        = S_INIT_ISS;
      end
      S_INIT_ISS: begin
        mm_req.vld = 1'b1;
        mm_opnd    = v_r;
        state_nxt  = S_INIT_WAIT;
      end
      S_INIT_WAIT: begin
        state_nxt = S_INIT_TAKE;
      end
      S_INIT_TAKE: begin
        // warm-up steps first, then fill the table from the top down
        v_nxt = {1'b0, mm_res};
        if (cnt_r < CNT_W'(TABLE_SIZE)) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = cnt_r[IDX_W-1:0];
          ram_wr_data = mm_res;
        end
        if (cnt_r == '0) begin
          first_state_nxt = {1'b0, mm_res};
          last_output_nxt = mm_res;
          tbl_vld_nxt     = '1;
          state_nxt       = S_D0;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_INIT_ISS;
        end
      end
      S_D0: begin
        mm_req.vld = 1'b1;
        mm_req.sel = clsr_pkg::GEN_FIRST;
        mm_opnd    = first_state_r;
        q_nxt      = q_prod[31+MW-1:32];
        state_nxt  = S_D1;
      end
      S_D1: begin
        mm_req.vld = 1'b1;
        mm_req.sel = clsr_pkg::GEN_SECOND;
        mm_opnd    = {1'b0, second_state_r};
        qd_nxt     = (QW+31)'(q_inc) * (QW+31)'(DIVISOR);
        state_nxt  = S_D2;
      end
      S_D2: begin
        first_state_nxt = {1'b0, mm_res};
        idx_nxt         = (q_sel > IDX_MAX_Q) ? IDX_MAX_Q[IDX_W-1:0] : q_sel[IDX_W-1:0];
        state_nxt       = S_D3;
      end
      S_D3: begin
        second_state_nxt = mm_res;
        ram_rd_en        = 1'b1;
        state_nxt        = S_D4;
      end
      S_D4: begin
        // hold here until the output register is free
        if (out_free) begin
          ram_wr_en       = 1'b1;
          tbl_vld_nxt     = tbl_vld_r | (TABLE_SIZE'(1) << idx_r);
          last_output_nxt = diff_adj[30:0];
          out_word_nxt    = diff_adj[30:0];
          out_seed_nxt    = first_state_r[30:0];
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      first_state_r  <= '0;
      second_state_r <= clsr_pkg::SECOND_RESET;
      last_output_r  <= '0;
      tbl_vld_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      first_state_r  <= first_state_nxt;
      second_state_r <= second_state_nxt;
      last_output_r  <= last_output_nxt;
      tbl_vld_r      <= tbl_vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    qd_r       <= qd_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
    out_seed_r <= out_seed_nxt;
  end

  // unit results arrive only where the sequencer picks them up
  a_mm_res_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_res_vld |-> (state_r == S_D2 || state_r == S_D3 || state_r == S_INIT_TAKE))
    else $error("mod-mult result outside a pickup state");

  // second generator stays reduced below its modulus
  a_second_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, second_state_r} < clsr_pkg::MOD2)
    else $error("second generator state not reduced");

  // table index in range when the read goes out
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D3) |-> (32'(idx_r) < 32'(TABLE_SIZE)))
    else $error("shuffle index out of range");

  // a result that raises out_valid lies in 1..MOD1-1
  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_word_r != '0 && {1'b0, out_word_r} < clsr_pkg::MOD1))
    else $error("combined word out of range");

  // an accepted word always starts with the state check
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CHECK))
    else $error("accepted word did not enter the check state");

endmodule

/* bench/combined_lcg_shuffle_rng_top_test.sv */
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top_test: self-checking bench of the shuffled LCG
// Drives draw and seed words through the input channel, predicts each
// combined word and first-generator state with a bit-exact model of the two
// generators and the shuffle table, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module combined_lcg_shuffle_rng_top_test;

  localparam int TBL_WORDS      = 32;
  localparam int WATCHDOG_LIMIT = 3000;  // idle cycles before giving up
  localparam int LONG_HOLD      = 400;   // receiver hold-off for back-pressure
  localparam int DRAIN_CYCLES   = 200;   // beyond the worst reseed latency
  localparam int RANDOM_WORDS   = 650;

  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_SEED = 1'b1
  } draw_mode_t;

  typedef struct {
    clsr_pkg::word_t random_word;
    clsr_pkg::word_t next_seed;
  } draw_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of both generators and the shuffle table.
  // --------------------------------------------------------------------------
  class draw_scoreboard_t;
    logic [31:0]     lcg_a;
    clsr_pkg::word_t lcg_b;
    clsr_pkg::word_t shuffle_mem [TBL_WORDS];
    clsr_pkg::word_t prev_word;
    draw_t           draws_due [$];
    int              errors;

    function new();
      lcg_a     = '0;
      lcg_b     = clsr_pkg::SECOND_RESET;
      prev_word = '0;
      errors    = 0;
      foreach (shuffle_mem[i]) shuffle_mem[i] = '0;
    endfunction

    // Exact modular product; fits 64 bits for every operand used here.
    function longint unsigned mul_mod(longint unsigned v, longint unsigned mul,
                                      longint unsigned modulus);
      return (v * mul) % modulus;
    endfunction

    // Reinitialize from a magnitude: eight warm-up steps, then fill the
    // table from the top entry down.
    function void refill(longint unsigned mag);
      longint unsigned v;
      v     = mag;
      lcg_b = clsr_pkg::word_t'(mag % clsr_pkg::MOD2);
      for (int i = TBL_WORDS + 7; i >= 0; i--) begin
        v = mul_mod(v, clsr_pkg::MUL1, clsr_pkg::MOD1);
        if (i < TBL_WORDS) shuffle_mem[i] = clsr_pkg::word_t'(v);
      end
      lcg_a     = v[31:0];
      prev_word = shuffle_mem[0];
    endfunction

    function draw_t predict_draw(draw_mode_t m, clsr_pkg::seed_t s);
      longint unsigned mag;
      longint          comb;
      longint          picked;
      longint          second;
      int unsigned     idx;
      draw_t           d;
      if (m == MODE_SEED) lcg_a = s;
      // zero or negative state forces a reinit
      if (lcg_a == 0 || lcg_a[31]) begin
        mag = (lcg_a == 0) ? 64'd1 : (64'h1_0000_0000 - {32'd0, lcg_a});
        refill(mag);
      end
      lcg_a = 32'(mul_mod(lcg_a, clsr_pkg::MUL1, clsr_pkg::MOD1));
      lcg_b = clsr_pkg::word_t'(mul_mod(lcg_b, clsr_pkg::MUL2, clsr_pkg::MOD2));
      idx   = prev_word / (1 + clsr_pkg::MOD1_LESS1 / TBL_WORDS);
      if (idx >= TBL_WORDS) idx = unsigned'(TBL_WORDS - 1);
      picked           = shuffle_mem[idx];
      second           = lcg_b;
      comb             = picked - second;
      shuffle_mem[idx] = lcg_a[30:0];
      if (comb < 1) comb = comb + longint'(clsr_pkg::MOD1_LESS1);
      prev_word     = comb[30:0];
      d.random_word = prev_word;
      d.next_seed   = lcg_a[30:0];
      return d;
    endfunction

    function void note_word(draw_mode_t m, clsr_pkg::seed_t s);
      draws_due.push_back(predict_draw(m, s));
    endfunction

    function void check_result(clsr_pkg::word_t rw, clsr_pkg::word_t ns);
      draw_t d;
      if (draws_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word=%0d next_seed=%0d", $time, rw, ns);
        return;
      end
      d = draws_due.pop_front();
      if (rw !== d.random_word) begin
        errors++;
        $display("%0t: random_word mismatch expected %0d actual %0d",
                 $time, d.random_word, rw);
      end
      if (ns !== d.next_seed) begin
        errors++;
        $display("%0t: next_seed mismatch expected %0d actual %0d",
                 $time, d.next_seed, ns);
      end
    endfunction

    function int pending();
      return draws_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  clsr_in_if  in_ch ();
  clsr_out_if out_ch ();

  combined_lcg_shuffle_rng_top #(
    .TABLE_SIZE(TBL_WORDS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  draw_scoreboard_t sb = new();

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;
  int burst_left   = 0;

  // --------------------------------------------------------------------------
  // Monitors: note accepted input words, check accepted results.
  // Sample at the rising edge; every driver updates with nonblocking writes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      sb.note_word(draw_mode_t'(in_ch.mode), in_ch.seed);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.random_word, out_ch.next_seed);
  end

  // Watchdog: count cycles in which neither channel moves a word.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               sb.pending());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on one of four randomly picked patterns; take one long
  // hold-off when asked, counted here, while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int rx_style;
    int rx_cycle;
    hold_left = 0;
    rx_style  = 0;
    rx_cycle  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          0: begin
            out_ch.ready <= 1'b1;                        // stream freely
          end
          1: begin
            out_ch.ready <= 1'($urandom_range(0, 1));    // coin flip
          end
          2: begin
            out_ch.ready <= (rx_cycle % 4 != 3);        // drop every fourth
          end
          default: begin
            out_ch.ready <= ($urandom_range(0, 4) == 0); // mostly stalled
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Open a new burst after a random gap; drop valid only across real gaps so
  // valid never gets two writes in one step.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Offer one word and hold it until the block takes it.
  task automatic send_word(draw_mode_t m, clsr_pkg::seed_t s);
    pace_sender();
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.seed  <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Pick one random word: mostly draws, then positive and negative reseeds,
  // with the awkward seeds mixed in now and then.
  task automatic send_random_word();
    int              pick;
    clsr_pkg::seed_t s;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      send_word(MODE_DRAW, clsr_pkg::seed_t'($urandom));   // seed content ignored
    end else if (pick < 75) begin
      s = {1'b0, 31'($urandom)};
      if (s == 0) s = 1;
      send_word(MODE_SEED, s);
    end else if (pick < 80) begin
      send_word(MODE_SEED, clsr_pkg::seed_t'($urandom_range(1, 1000)));
    end else if (pick < 88) begin
      send_word(MODE_SEED, {1'b1, 31'($urandom)});
    end else if (pick < 92) begin
      send_word(MODE_SEED, -clsr_pkg::seed_t'($urandom_range(1, 1000)));
    end else begin
      case ($urandom_range(0, 4))
        0: s = 32'sd0;
        1: s = clsr_pkg::seed_t'(clsr_pkg::MOD1);         // first step yields zero
        2: s = -clsr_pkg::seed_t'(clsr_pkg::MOD1);        // table fills with zeros
        3: s = 32'sh8000_0000;                            // most negative
        default: s = 32'sh7FFF_FFFF;
      endcase
      send_word(MODE_SEED, s);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_DRAW;
    in_ch.seed  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Load a positive seed straight after reset: draws from the empty table.
    send_word(MODE_SEED, 32'sd12345);
    send_word(MODE_DRAW, 32'sh7FFF_FFFF);            // seed bits ignored
    send_word(MODE_DRAW, 32'sh0000_0000);
    // Zero seed reinitializes with magnitude one.
    send_word(MODE_SEED, 32'sd0);
    send_word(MODE_DRAW, 32'shFFFF_FFFF);
    // Minus one, then the most negative seed (magnitude 2^31).
    send_word(MODE_SEED, -32'sd1);
    send_word(MODE_DRAW, 32'sh5555_5555);
    send_word(MODE_SEED, 32'sh8000_0000);
    send_word(MODE_DRAW, 32'shAAAA_AAAA);
    send_word(MODE_DRAW, 32'sd0);
    // Largest positive seed, above the first modulus.
    send_word(MODE_SEED, 32'sh7FFF_FFFF);
    send_word(MODE_DRAW, 32'sd0);
    // A seed equal to the first modulus gives a zero state; the following
    // draw from the held state reinitializes with magnitude one.
    send_word(MODE_SEED, clsr_pkg::seed_t'(clsr_pkg::MOD1));
    send_word(MODE_DRAW, 32'sd0);
    send_word(MODE_DRAW, 32'sd0);
    // Negative seed of modulus magnitude: every table entry ends up zero.
    send_word(MODE_SEED, -clsr_pkg::seed_t'(clsr_pkg::MOD1));
    send_word(MODE_DRAW, 32'sd0);
    send_word(MODE_DRAW, 32'sd0);
    // Smallest positive seed and a small negative one.
    send_word(MODE_SEED, 32'sd1);
    send_word(MODE_DRAW, 32'sd0);
    send_word(MODE_SEED, -32'sd123456);
    send_word(MODE_DRAW, 32'sd0);

    // Random part; ask for the long hold-off partway through.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) hold_request = 1'b1;
      send_random_word();
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every expected result, then a quiet stretch to catch
    // anything extra. The watchdog bounds both waits.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/clsr_pkg.sv
rtl/core/clsr_in_if.sv
rtl/core/clsr_out_if.sv
rtl/core/clsr_ram.sv
rtl/core/clsr_mmul.sv
rtl/core/combined_lcg_shuffle_rng_top.sv
bench/combined_lcg_shuffle_rng_top_test.sv
